FILE: rtl/core/io_work_dispatcher_core_defines.svh
// ----------------------------------------------------------------------------
// io_work_dispatcher_core_defines : assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef IO_WORK_DISPATCHER_CORE_DEFINES_SVH
`define IO_WORK_DISPATCHER_CORE_DEFINES_SVH

// Same-cycle implication.
`define WD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("io_work_dispatcher_core: assertion failed");

// Next-cycle implication.
`define WD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("io_work_dispatcher_core: assertion failed");

`endif

FILE: rtl/core/io_wd_pkg.sv
// ----------------------------------------------------------------------------
// io_wd_pkg : shared types and constants
// Word formats, action and status codes, register map, priority pick.
// ----------------------------------------------------------------------------
package io_wd_pkg;

  localparam int unsigned JOB_ID_BITS     = 16;
  localparam int unsigned WORKER_ID_BITS  = 5;
  localparam int unsigned DEPTH_BITS      = 6;
  localparam int unsigned QLOG2_BITS      = 3;
  localparam int unsigned PADDR_BITS      = 3;
  localparam int unsigned PDATA_BITS      = 32;
  localparam int unsigned WAKE_FANOUT     = 2;
  localparam int unsigned RING_DEPTH_DEF  = 64;
  localparam int unsigned MAX_WORKERS_DEF = 32;
  localparam logic [QLOG2_BITS-1:0] QLOG2_RESET = 3'd6;

  typedef enum logic [1:0] {
    ACT_SUBMIT,
    ACT_POLL,
    ACT_REGISTER,
    ACT_LEAVE
  } action_t;

  typedef enum logic [2:0] {
    ST_QUEUED,
    ST_SYNC_REOPEN,
    ST_SYNC_FULL,
    ST_TAKEN,
    ST_IDLE,
    ST_REGISTERED,
    ST_LEFT
  } status_t;

  typedef enum logic {
    REG_QUEUE_SIZE,
    REG_SINGLE_USER
  } reg_idx_t;

  typedef struct packed {
    action_t                   action;
    logic [JOB_ID_BITS-1:0]    job_id;
    logic                      can_reopen;
    logic                      batch_start;
    logic [WORKER_ID_BITS-1:0] worker_id;
  } in_word_t;

  typedef struct packed {
    status_t                   status;
    logic [JOB_ID_BITS-1:0]    out_job_id;
    logic                      wake_a_valid;
    logic [WORKER_ID_BITS-1:0] wake_a_worker;
    logic                      wake_b_valid;
    logic [WORKER_ID_BITS-1:0] wake_b_worker;
    logic [DEPTH_BITS-1:0]     queue_depth;
  } out_word_t;

  typedef struct packed {
    logic [QLOG2_BITS-1:0] queue_size_log2;
    logic                  single_user;
    logic                  clear_ptrs;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic       found;
    logic [5:0] idx;
  } pick_t;

  // lowest set bit of a 64-bit vector
  function automatic pick_t pick_lowest(input logic [63:0] v);
    pick_t p;
    p = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) begin
        p.found = 1'b1;
        p.idx   = 6'(i);
      end
    end
    return p;
  endfunction

endpackage

FILE: rtl/core/io_work_dispatcher_core.sv
// A request word is registered when accepted, and its result word is registered
//   once the result register is free. The core takes no new request word until
//   the one it holds has been committed, so only one word is in flight at a time.
// Reset: synchronous, active low; ring empty, no worker idle, queue size 64,
//   single-user mode off. Ring contents are not cleared.
// ----------------------------------------------------------------------------
// io_work_dispatcher_core : job id dispatcher to a worker pool
// Ring FIFO of job ids with lowest-idle-worker wakeup, APB-style config port.
// ----------------------------------------------------------------------------
module io_work_dispatcher_core
  import io_wd_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  // register 0 (queue size) at byte 0, register 1 (single user) at byte 4
  io_wd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: takes a word in idle, commits it when the result register
  // is empty or being drained this cycle
  io_wd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: ring, pointers, idle set, two priority picks, result register
  io_wd_dpath #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: rtl/core/io_wd_cfg.sv
// ----------------------------------------------------------------------------
// io_wd_cfg : configuration registers
// APB-style write/read of queue size and single-user mode.
// ----------------------------------------------------------------------------
module io_wd_cfg
  import io_wd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [QLOG2_BITS-1:0] qlog2_r;
  logic                  single_r;
  logic                  wr_en;
  reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlog2_r  <= QLOG2_RESET;
      single_r <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_QUEUE_SIZE:  qlog2_r  <= pwdata[QLOG2_BITS-1:0];
        REG_SINGLE_USER: single_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_QUEUE_SIZE:  prdata = PDATA_BITS'(qlog2_r);
      REG_SINGLE_USER: prdata = PDATA_BITS'(single_r);
      default:         prdata = '0;
    endcase
  end

  // a size write empties the ring
  assign cfg.queue_size_log2 = qlog2_r;
  assign cfg.single_user     = single_r;
  assign cfg.clear_ptrs      = wr_en && (idx == REG_QUEUE_SIZE);

endmodule

FILE: rtl/core/io_wd_ctrl.sv
// ----------------------------------------------------------------------------
// io_wd_ctrl : request sequencer
// Accepts one word, commits it once the result register is free.
// ----------------------------------------------------------------------------
module io_wd_ctrl
  import io_wd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/io_wd_dpath.sv
// ----------------------------------------------------------------------------
// io_wd_dpath : ring store, pointers, idle set and result register
// One commit applies a submit, poll, register or leave.
// ----------------------------------------------------------------------------
module io_wd_dpath
  import io_wd_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  cfg_t      cfg,
  input  in_word_t  in_data,
  output out_word_t out_data
);

  // largest power of two not above RING_DEPTH
  localparam int unsigned LG_MAX    = $clog2(RING_DEPTH + 1) - 1;
  localparam int unsigned PTR_W     = LG_MAX;
  localparam int unsigned MEM_DEPTH = 1 << PTR_W;
  localparam int unsigned DW        = (PTR_W > DEPTH_BITS) ? PTR_W : DEPTH_BITS;

  logic [JOB_ID_BITS-1:0] mem [MEM_DEPTH];
  logic [JOB_ID_BITS-1:0] rdata_r;
  in_word_t               req_r;
  out_word_t              out_r, out_nxt;
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [MAX_WORKERS-1:0] idle_r, idle_nxt;
  logic                   woken_r, woken_nxt;
  logic                   push;

  logic [QLOG2_BITS-1:0]  lg_raw;
  logic [3:0]             lg_eff;
  logic [PTR_W-1:0]       mask;

  assign lg_raw = (cfg.queue_size_log2 == '0) ? QLOG2_BITS'(1) : cfg.queue_size_log2;
  assign lg_eff = (4'(lg_raw) > 4'(LG_MAX)) ? 4'(LG_MAX) : 4'(lg_raw);

  always_comb begin
    for (int i = 0; i < PTR_W; i++) begin
      mask[i] = (i < int'(lg_eff));
    end
  end

  always_comb begin
    logic [MAX_WORKERS-1:0] wbit;
    logic [MAX_WORKERS-1:0] pool;
    logic [MAX_WORKERS-1:0] a_bit;
    logic [MAX_WORKERS-1:0] b_bit;
    logic [63:0]            a_hot;
    logic [63:0]            b_hot;
    logic [PTR_W-1:0]       wr_inc;
    logic [PTR_W-1:0]       rd_inc;
    logic [PTR_W-1:0]       left;
    logic [PTR_W-1:0]       depth;
    logic [DW-1:0]          depth_ext;
    logic                   empty;
    logic                   full;
    logic                   woken;
    pick_t                  pick_a;
    pick_t                  pick_b;

    for (int i = 0; i < MAX_WORKERS; i++) begin
      wbit[i] = (int'(req_r.worker_id) == i);
    end
    wr_inc = (wr_ptr_r + PTR_W'(1)) & mask;
    rd_inc = (rd_ptr_r + PTR_W'(1)) & mask;
    empty  = (wr_ptr_r == rd_ptr_r);
    full   = (wr_inc == rd_ptr_r);
    left   = (wr_ptr_r - rd_inc) & mask;

    // submit picks from the idle set, a poll first drops its own worker
    pool   = (req_r.action == ACT_SUBMIT) ? idle_r : (idle_r & ~wbit);
    pick_a = pick_lowest(64'(pool));
    a_hot  = 64'(1) << pick_a.idx;
    pick_b = pick_lowest(64'(pool) & ~a_hot);
    b_hot  = 64'(1) << pick_b.idx;
    a_bit  = a_hot[MAX_WORKERS-1:0];
    b_bit  = b_hot[MAX_WORKERS-1:0];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    idle_nxt   = idle_r;
    woken_nxt  = woken_r;
    push       = 1'b0;
    out_nxt    = '0;
    woken      = woken_r;

    case (req_r.action)
      ACT_SUBMIT: begin
        woken = req_r.batch_start ? 1'b0 : woken_r;
        if (cfg.single_user || !req_r.can_reopen) begin
          out_nxt.status = ST_SYNC_REOPEN;
        end else if (full) begin
          out_nxt.status = ST_SYNC_FULL;
        end else begin
          push           = 1'b1;
          wr_ptr_nxt     = wr_inc;
          out_nxt.status = ST_QUEUED;
          if (!woken && pick_a.found) begin
            woken                 = 1'b1;
            idle_nxt              = idle_r & ~a_bit;
            out_nxt.wake_a_valid  = 1'b1;
            out_nxt.wake_a_worker = pick_a.idx[WORKER_ID_BITS-1:0];
          end
        end
        woken_nxt = woken;
      end
      ACT_POLL: begin
        if (empty) begin
          idle_nxt       = idle_r | wbit;
          out_nxt.status = ST_IDLE;
        end else begin
          rd_ptr_nxt         = rd_inc;
          out_nxt.status     = ST_TAKEN;
          out_nxt.out_job_id = rdata_r;
          idle_nxt           = pool;
          if ((left != '0) && pick_a.found) begin
            out_nxt.wake_a_valid  = 1'b1;
            out_nxt.wake_a_worker = pick_a.idx[WORKER_ID_BITS-1:0];
            idle_nxt              = pool & ~a_bit;
            if ((32'(left) >= WAKE_FANOUT) && pick_b.found) begin
              out_nxt.wake_b_valid  = 1'b1;
              out_nxt.wake_b_worker = pick_b.idx[WORKER_ID_BITS-1:0];
              idle_nxt              = pool & ~a_bit & ~b_bit;
            end
          end
        end
      end
      ACT_REGISTER: begin
        idle_nxt       = idle_r | wbit;
        out_nxt.status = ST_REGISTERED;
      end
      ACT_LEAVE: begin
        idle_nxt       = idle_r & ~wbit;
        out_nxt.status = ST_LEFT;
      end
      default: out_nxt.status = ST_LEFT;
    endcase

    depth               = (wr_ptr_nxt - rd_ptr_nxt) & mask;
    depth_ext           = DW'(depth);
    out_nxt.queue_depth = depth_ext[DEPTH_BITS-1:0];
  end

  // ring store: one write, one registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.commit && push) begin
      mem[wr_ptr_r] <= req_r.job_id;
    end
    rdata_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      idle_r   <= '0;
      woken_r  <= 1'b0;
    end else if (cfg.clear_ptrs) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else if (cmd.commit) begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      idle_r   <= idle_nxt;
      woken_r  <= woken_nxt;
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/core/io_wd_checker.sv
// ----------------------------------------------------------------------------
// io_wd_checker : port-level checks for io_work_dispatcher_core
// Bound to the top level; watches handshakes and result word consistency.
// ----------------------------------------------------------------------------
`include "io_work_dispatcher_core_defines.svh"

module io_wd_checker
  import io_wd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  `WD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `WD_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)
  `WD_ASSERT_NEXT(a_result_follows, in_stall && !out_valid, out_valid)
  `WD_ASSERT_IMP(a_second_wake, out_valid && out_data.wake_b_valid, out_data.wake_a_valid && (out_data.status == ST_TAKEN))
  `WD_ASSERT_IMP(a_job_only_taken, out_valid && (out_data.status != ST_TAKEN), (out_data.out_job_id == '0) && !out_data.wake_b_valid)

endmodule

bind io_work_dispatcher_core io_wd_checker u_io_wd_checker (.*);

FILE: sim/io_work_dispatcher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_work_dispatcher_core_tb : self-checking bench for the job dispatcher
// Directed and random request words go through the core under random idling
// and back-pressure. A behavioural copy of the ring, the idle set and the
// batch flag predicts every result word, and the monitor checks each one in
// order. The ring size and single-user mode are changed between phases.
// ----------------------------------------------------------------------------
module io_work_dispatcher_core_tb;
  import io_wd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000; // quiet cycles before giving up
  localparam int unsigned GAP_PCT        = 31;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned HOLD_CYCLES    = 300;  // long receiver hold-off
  localparam int unsigned TAIL_CYCLES    = 10;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [PADDR_BITS-1:0] paddr    = '0;
  logic [PDATA_BITS-1:0] pwdata   = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  io_work_dispatcher_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_word_t    request_backlog[$];   // words waiting to be offered
  out_word_t   expected_replies[$];  // predicted result words, oldest first

  int unsigned src_gap_pct    = GAP_PCT;
  int unsigned sink_stall_pct = GAP_PCT;
  int unsigned stall_burst_req;      // set by stimulus, taken by the sink
  int unsigned stall_burst_left;

  int unsigned mismatch_count;
  int unsigned requests_taken;
  int unsigned replies_seen;
  int unsigned quiet_cycles;
  int unsigned wake_a_count;
  int unsigned wake_b_count;
  int unsigned status_hits [8];

  // phase table
  int unsigned phase_qlog2  [NUM_PHASES];
  int unsigned phase_single [NUM_PHASES];
  int unsigned phase_items  [NUM_PHASES];
  int unsigned phase_submit [NUM_PHASES];
  int unsigned phase_poll   [NUM_PHASES];

  // --------------------------------------------------------------------------
  // Dispatcher model: ring of job ids, idle set, batch wake flag, config
  // --------------------------------------------------------------------------
  logic [JOB_ID_BITS-1:0]     ring_copy [RING_DEPTH_DEF];
  int unsigned                wr_ptr;
  int unsigned                rd_ptr;
  logic [MAX_WORKERS_DEF-1:0] idle_set;
  logic                       batch_woken;
  logic [QLOG2_BITS-1:0]      qsize_log2;
  logic                       single_user_mode;

  // active size: log2 of zero acts as one, anything past the store is clipped
  function automatic int unsigned ring_mask();
    int unsigned lg;
    lg = (qsize_log2 == 0) ? 1 : qsize_log2;
    if ((1 << lg) > RING_DEPTH_DEF) return RING_DEPTH_DEF - 1;
    return (1 << lg) - 1;
  endfunction

  // lowest-numbered idle worker, taken out of the set; -1 if nobody idles
  function automatic int grab_idle_worker();
    for (int w = 0; w < MAX_WORKERS_DEF; w++) begin
      if (idle_set[w]) begin
        idle_set[w] = 1'b0;
        return w;
      end
    end
    return -1;
  endfunction

  function automatic out_word_t predict_dispatch(in_word_t req);
    out_word_t   rsp;
    int unsigned mask;
    int unsigned depth;
    int unsigned fan;
    int          w;
    rsp    = '0;
    mask   = ring_mask();
    wr_ptr = wr_ptr & mask;
    rd_ptr = rd_ptr & mask;
    case (req.action)
      ACT_SUBMIT: begin
        if (req.batch_start) batch_woken = 1'b0;
        if (single_user_mode || !req.can_reopen) begin
          rsp.status = ST_SYNC_REOPEN;
        end else if (((wr_ptr + 1) & mask) == rd_ptr) begin
          rsp.status = ST_SYNC_FULL;
        end else begin
          ring_copy[wr_ptr] = req.job_id;
          wr_ptr     = (wr_ptr + 1) & mask;
          rsp.status = ST_QUEUED;
          // one wakeup per batch; if nobody idles the flag stays clear
          if (!batch_woken) begin
            w = grab_idle_worker();
            if (w >= 0) begin
              batch_woken       = 1'b1;
              rsp.wake_a_valid  = 1'b1;
              rsp.wake_a_worker = WORKER_ID_BITS'(w);
            end
          end
        end
      end
      ACT_POLL: begin
        if (rd_ptr == wr_ptr) begin
          idle_set[req.worker_id] = 1'b1;
          rsp.status = ST_IDLE;
        end else begin
          rsp.out_job_id = ring_copy[rd_ptr];
          rd_ptr = (rd_ptr + 1) & mask;
          idle_set[req.worker_id] = 1'b0;  // poller is busy before others wake
          rsp.status = ST_TAKEN;
          depth = (wr_ptr - rd_ptr) & mask;
          fan   = (depth < WAKE_FANOUT) ? depth : WAKE_FANOUT;
          for (int i = 0; i < fan; i++) begin
            w = grab_idle_worker();
            if (w < 0) break;
            if (i == 0) begin
              rsp.wake_a_valid  = 1'b1;
              rsp.wake_a_worker = WORKER_ID_BITS'(w);
            end else begin
              rsp.wake_b_valid  = 1'b1;
              rsp.wake_b_worker = WORKER_ID_BITS'(w);
            end
          end
        end
      end
      ACT_REGISTER: begin
        idle_set[req.worker_id] = 1'b1;
        rsp.status = ST_REGISTERED;
      end
      default: begin
        idle_set[req.worker_id] = 1'b0;
        rsp.status = ST_LEFT;
      end
    endcase
    rsp.queue_depth = DEPTH_BITS'((wr_ptr - rd_ptr) & mask);
    return rsp;
  endfunction

  function automatic void note_mismatch(string what, out_word_t want, out_word_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s", $time, what);
      $display("  exp st=%0d job=%h a=%b/%0d b=%b/%0d depth=%0d", want.status,
               want.out_job_id, want.wake_a_valid, want.wake_a_worker,
               want.wake_b_valid, want.wake_b_worker, want.queue_depth);
      $display("  got st=%0d job=%h a=%b/%0d b=%b/%0d depth=%0d", got.status,
               got.out_job_id, got.wake_a_valid, got.wake_a_worker,
               got.wake_b_valid, got.wake_b_worker, got.queue_depth);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic in_word_t make_request(action_t act, logic [JOB_ID_BITS-1:0] job,
                                            logic reopen, logic bstart,
                                            logic [WORKER_ID_BITS-1:0] wid);
    in_word_t r;
    r.action      = act;
    r.job_id      = job;
    r.can_reopen  = reopen;
    r.batch_start = bstart;
    r.worker_id   = wid;
    return r;
  endfunction

  // mostly reopenable jobs so that the ring actually fills and drains
  function automatic in_word_t random_request(int unsigned submit_pct, int unsigned poll_pct);
    in_word_t    r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < submit_pct)                 r.action = ACT_SUBMIT;
    else if (roll < submit_pct + poll_pct) r.action = ACT_POLL;
    else if ($urandom_range(2) != 0)       r.action = ACT_REGISTER;
    else                                   r.action = ACT_LEAVE;
    r.job_id      = JOB_ID_BITS'($urandom);
    r.can_reopen  = ($urandom_range(99) < 88);
    r.batch_start = ($urandom_range(3) == 0);
    r.worker_id   = WORKER_ID_BITS'($urandom);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: payload held while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
        in_data  <= request_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stalls plus an occasional long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_burst_req != 0) begin
        stall_burst_left = stall_burst_req;
        stall_burst_req  = 0;
      end
      if (stall_burst_left != 0) begin
        stall_burst_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : reply_monitor
    out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(predict_dispatch(in_data));
        requests_taken++;
      end
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (!$isunknown(out_data.status)) status_hits[out_data.status]++;
        if (out_data.wake_a_valid === 1'b1) wake_a_count++;
        if (out_data.wake_b_valid === 1'b1) wake_b_count++;
        if (expected_replies.size() == 0) begin
          note_mismatch("result word with nothing outstanding", '0, out_data);
        end else begin
          want = expected_replies.pop_front();
          if (out_data !== want) note_mismatch("result word differs", want, out_data);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no word moving on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_replies.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Config write: setup then access cycle; model follows once written
  // --------------------------------------------------------------------------
  task automatic write_reg(reg_idx_t idx, logic [PDATA_BITS-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_QUEUE_SIZE) begin
      qsize_log2 = value[QLOG2_BITS-1:0];
      wr_ptr     = 0;  // a size change empties the ring
      rd_ptr     = 0;
    end else begin
      single_user_mode = value[0];
    end
  endtask

  // sender holds back until every predicted word has come out
  task automatic wait_for_drain();
    do @(negedge clk);
    while (request_backlog.size() != 0 || in_valid || expected_replies.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    phase_qlog2  = '{2, 0, 3, 7, 6, 1, 5, 4};
    phase_single = '{0, 0, 1, 0, 0, 0, 1, 0};
    phase_items  = '{130, 100, 100, 200, 150, 110, 100, 150};
    phase_submit = '{45, 40, 45, 80, 35, 50, 45, 45};
    phase_poll   = '{35, 40, 30, 12, 45, 30, 30, 35};

    wr_ptr           = 0;
    rd_ptr           = 0;
    idle_set         = '0;
    batch_woken      = 1'b0;
    qsize_log2       = QLOG2_RESET;
    single_user_mode = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: refusal, idle marking, batch wakes, nobody
    // idle, fan-out of two on a deep ring, extreme ids and worker numbers
    @(negedge clk);
    request_backlog.push_back(make_request(ACT_SUBMIT,   16'hFFFF, 1'b0, 1'b1, 5'd0));
    request_backlog.push_back(make_request(ACT_POLL,     16'h0000, 1'b0, 1'b0, 5'd31));
    request_backlog.push_back(make_request(ACT_POLL,     16'hFFFF, 1'b1, 1'b1, 5'd0));
    request_backlog.push_back(make_request(ACT_REGISTER, 16'h0000, 1'b0, 1'b0, 5'd5));
    request_backlog.push_back(make_request(ACT_LEAVE,    16'h0000, 1'b0, 1'b0, 5'd31));
    request_backlog.push_back(make_request(ACT_SUBMIT,   16'h0000, 1'b1, 1'b1, 5'd31));
    request_backlog.push_back(make_request(ACT_SUBMIT,   16'hFFFF, 1'b1, 1'b0, 5'd0));
    request_backlog.push_back(make_request(ACT_SUBMIT,   16'hA5A5, 1'b1, 1'b1, 5'd0));
    request_backlog.push_back(make_request(ACT_SUBMIT,   16'h5A5A, 1'b1, 1'b1, 5'd0));
    request_backlog.push_back(make_request(ACT_REGISTER, 16'h0000, 1'b0, 1'b0, 5'd3));
    request_backlog.push_back(make_request(ACT_REGISTER, 16'h0000, 1'b0, 1'b0, 5'd7));
    request_backlog.push_back(make_request(ACT_REGISTER, 16'h0000, 1'b0, 1'b0, 5'd9));
    request_backlog.push_back(make_request(ACT_REGISTER, 16'h0000, 1'b0, 1'b0, 5'd31));
    request_backlog.push_back(make_request(ACT_SUBMIT,   16'h1234, 1'b1, 1'b0, 5'd0));
    request_backlog.push_back(make_request(ACT_POLL,     16'h0000, 1'b0, 1'b0, 5'd7));
    request_backlog.push_back(make_request(ACT_POLL,     16'h0000, 1'b0, 1'b0, 5'd31));
    request_backlog.push_back(make_request(ACT_REGISTER, 16'h0000, 1'b0, 1'b0, 5'd0));
    request_backlog.push_back(make_request(ACT_REGISTER, 16'h0000, 1'b0, 1'b0, 5'd1));
    request_backlog.push_back(make_request(ACT_POLL,     16'h0000, 1'b0, 1'b0, 5'd2));
    wait_for_drain();

    // smallest ring: one slot usable, then full, then back to empty
    write_reg(REG_QUEUE_SIZE, 32'd1);
    @(negedge clk);
    request_backlog.push_back(make_request(ACT_SUBMIT, 16'h00FF, 1'b1, 1'b1, 5'd0));
    request_backlog.push_back(make_request(ACT_SUBMIT, 16'hFF00, 1'b1, 1'b0, 5'd0));
    request_backlog.push_back(make_request(ACT_POLL,   16'h0000, 1'b0, 1'b0, 5'd4));
    request_backlog.push_back(make_request(ACT_POLL,   16'h0000, 1'b0, 1'b0, 5'd4));
    wait_for_drain();

    // random phases; phase 3 runs flat out with no idling on either side,
    // phase 4 gets a long receiver hold-off so the core backs up
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_QUEUE_SIZE, phase_qlog2[p]);
      write_reg(REG_SINGLE_USER, phase_single[p]);
      @(negedge clk);
      src_gap_pct    = (p == 3) ? 0 : GAP_PCT;
      sink_stall_pct = (p == 3) ? 0 : GAP_PCT;
      for (int n = 0; n < phase_items[p]; n++)
        request_backlog.push_back(random_request(phase_submit[p], phase_poll[p]));
      if (p == 4) stall_burst_req = HOLD_CYCLES;
      wait_for_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $display("%0d result words never arrived", expected_replies.size());
      mismatch_count += expected_replies.size();
    end

    $display("covered %0d requests / %0d results over ring sizes 2..64 and single-user mode",
             requests_taken, replies_seen);
    $display("queued %0d, refused %0d, full %0d, taken %0d, idle %0d, wakes %0d+%0d",
             status_hits[ST_QUEUED], status_hits[ST_SYNC_REOPEN], status_hits[ST_SYNC_FULL],
             status_hits[ST_TAKEN], status_hits[ST_IDLE], wake_a_count, wake_b_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/io_wd_pkg.sv
rtl/core/io_wd_cfg.sv
rtl/core/io_wd_ctrl.sv
rtl/core/io_wd_dpath.sv
rtl/core/io_work_dispatcher_core.sv
rtl/core/io_wd_checker.sv
sim/io_work_dispatcher_core_tb.sv
